// ===== src/wbps_pkg.sv =====
package wbps_pkg;

    localparam int PAT_BYTES = 16;  // pattern storage, fixed by the two 64-bit registers
    localparam int PLEN_W    = 5;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 64;
    localparam int CIDX_W    = 2;
    localparam int M_DATA_W  = 40;  // 34 bits of fields, padded to bytes

    typedef enum logic [CIDX_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_CARE     = 2'd2,
        REG_LEN      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pattern;
        logic [PAT_BYTES-1:0]      care;
        logic [PLEN_W-1:0]         len;   // already clipped to the window depth
        logic                      bad;
    } cfg_t;

    typedef struct packed {
        logic             emit;
        logic             found;
        logic [CNT_W-1:0] offset;
        logic             bad;
    } res_t;

endpackage

// ===== src/wbps_cfg.sv =====
module wbps_cfg #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [wbps_pkg::CIDX_W-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]  cfg_wdata,
    output wbps_pkg::cfg_t              cfg
);
    import wbps_pkg::*;

    logic [CFG_W-1:0]     pat_low_reg;
    logic [CFG_W-1:0]     pat_high_reg;
    logic [PAT_BYTES-1:0] care_reg;
    logic [PLEN_W-1:0]    plen_reg;
    logic [PLEN_W-1:0]    len_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= PAT_BYTES'(1);
            plen_reg     <= PLEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                REG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                REG_CARE:     care_reg     <= cfg_wdata[PAT_BYTES-1:0];
                REG_LEN:      plen_reg     <= cfg_wdata[PLEN_W-1:0];
            endcase
        end
    end

    // lengths beyond the window saturate
    assign len_used = (plen_reg > PLEN_W'(MAX_PATTERN_BYTES)) ?
                      PLEN_W'(MAX_PATTERN_BYTES) : plen_reg;

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.care    = care_reg;
    assign cfg.len     = len_used;
    assign cfg.bad     = (len_used == '0) || !care_reg[0];

endmodule

// ===== src/wbps_match.sv =====
module wbps_match #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
    input  wbps_pkg::cfg_t                    cfg,
    output logic                              hit
);
    import wbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    // pattern byte j lines up with window entry len-1-j (window is newest first)
    always_comb begin
        logic [PLEN_W-1:0] idx;
        logic              active;
        hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            idx    = cfg.len - PLEN_W'(1) - PLEN_W'(j);
            active = PLEN_W'(j) < cfg.len;
            if (active && cfg.care[j] && (window[idx[IDX_W-1:0]] != cfg.pattern[j])) begin
                hit = 1'b0;
            end
        end
    end

endmodule

// ===== src/wbps_track.sv =====
module wbps_track #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    input  wbps_pkg::cfg_t                    cfg,
    input  logic                              win_hit,
    output logic [MAX_PATTERN_BYTES-1:0][7:0] win_next,
    output wbps_pkg::res_t                    res
);
    import wbps_pkg::*;

    logic [MAX_PATTERN_BYTES-1:0][7:0] win_reg;
    logic [CNT_W-1:0]                  seen_reg;
    logic [CNT_W-1:0]                  seen_next;
    logic                              reported_reg;
    logic                              counted;
    logic                              fire;

    always_comb begin
        win_next[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    // count saturates; no match is tested once it is stuck
    assign counted   = (seen_reg != '1);
    assign seen_next = counted ? seen_reg + CNT_W'(1) : seen_reg;

    assign fire = !reported_reg && counted && !cfg.bad &&
                  (seen_next >= CNT_W'(cfg.len)) && win_hit;

    assign res.emit   = fire || (last_byte && !reported_reg);
    assign res.found  = fire;
    assign res.offset = fire ? seen_next - CNT_W'(cfg.len) : '0;
    assign res.bad    = !fire && cfg.bad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= '0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else if (step) begin
            if (last_byte) begin
                win_reg      <= '0;
                seen_reg     <= '0;
                reported_reg <= 1'b0;
            end else begin
                win_reg      <= win_next;
                seen_reg     <= seen_next;
                reported_reg <= reported_reg || fire;
            end
        end
    end

endmodule

// ===== src/wildcard_byte_pattern_scan.sv =====
// channel   dir  ports                    payload
// s_        in   tvalid tready tdata tlast  data_byte, last_byte
// m_        out  tvalid tready tdata        match_found, match_offset, bad_pattern
// cfg_      in   we index wdata             pattern low/high, care mask, length
//
// One item per cycle while m_tready keeps the result register free: an input
// register, the masked window compare and the count update in one step, then a
// result register.
// A stalled result holds the pipe; the input register still takes one item.
// aresetn is synchronous and clears window, count and configuration.
module wildcard_byte_pattern_scan #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] match_found, [32:1] match_offset, [33] bad_pattern, [39:34] zero
    output logic [wbps_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic [wbps_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]    cfg_wdata
);
    import wbps_pkg::*;

    cfg_t                              cfg;
    res_t                              res;
    logic [MAX_PATTERN_BYTES-1:0][7:0] win_next;
    logic                              win_hit;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [CNT_W-1:0] out_offset_reg;
    logic             out_bad_reg;
    logic             out_free;
    logic             step;
    logic             emit;

    wbps_cfg #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wbps_track #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .win_hit   (win_hit),
        .win_next  (win_next),
        .res       (res)
    );

    wbps_match #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_match (
        .window (win_next),
        .cfg    (cfg),
        .hit    (win_hit)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign emit     = step && res.emit;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_found_reg  <= res.found;
            out_offset_reg <= res.offset;
            out_bad_reg    <= res.bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - CNT_W - 2){1'b0}}, out_bad_reg, out_offset_reg,
                       out_found_reg};

endmodule

// ===== tb/tb_wildcard_byte_pattern_scan.sv =====
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scan;
    import wbps_pkg::*;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic        bad;
    } scan_result_t;

    class scan_scoreboard;
        logic [127:0] pattern;
        logic [15:0]  care;
        logic [4:0]   plen;
        logic [7:0]   window [16];   // newest byte at index 0
        logic [31:0]  seen;
        bit           reported;
        scan_result_t expected_q [$];
        int           errors;

        function new();
            pattern = '0;
            care    = 16'h0001;
            plen    = 5'd1;
            errors  = 0;
            clear_region();
        endfunction

        function void clear_region();
            for (int i = 0; i < 16; i++) window[i] = 8'h00;
            seen     = '0;
            reported = 1'b0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_PAT_LOW:  pattern[63:0]   = v;
                REG_PAT_HIGH: pattern[127:64] = v;
                REG_CARE:     care            = v[15:0];
                REG_LEN:      plen            = v[4:0];
                default: ;
            endcase
        endfunction

        function int used_len();
            return (plen > 5'd16) ? 16 : int'(plen);
        endfunction

        function bit window_hit(int n);
            for (int j = 0; j < n; j++) begin
                if (care[j] && window[n-1-j] != pattern[8*j +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            int           n;
            bit           counted;
            bit           bad;
            scan_result_t r;
            n       = used_len();
            bad     = (n == 0) || !care[0];
            counted = (seen != 32'hFFFF_FFFF);
            for (int i = 15; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            if (counted) seen++;
            if (!reported && counted && !bad && seen >= n && window_hit(n)) begin
                r.found  = 1'b1;
                r.offset = seen - 32'(n);
                r.bad    = 1'b0;
                expected_q = {expected_q, r};
                reported = 1'b1;
            end else if (l && !reported) begin
                r.found  = 1'b0;
                r.offset = '0;
                r.bad    = bad;
                expected_q = {expected_q, r};
            end
            if (l) clear_region();
        endfunction

        function void check_result(logic [M_DATA_W-1:0] d);
            scan_result_t got;
            scan_result_t want;
            got.found  = d[0];
            got.offset = d[32:1];
            got.bad    = d[33];
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0b offset=%0d bad=%0b",
                         $time, got.found, got.offset, got.bad);
                return;
            end
            want = expected_q.pop_front();
            if (got.found !== want.found) begin
                errors++;
                $display("%0t: match_found expected %0b actual %0b",
                         $time, want.found, got.found);
            end
            if (got.offset !== want.offset) begin
                errors++;
                $display("%0t: match_offset expected %0d actual %0d",
                         $time, want.offset, got.offset);
            end
            if (got.bad !== want.bad) begin
                errors++;
                $display("%0t: bad_pattern expected %0b actual %0b",
                         $time, want.bad, got.bad);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    wire                   s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  s_tlast   = 1'b0;
    wire                   m_tvalid;
    logic                  m_tready  = 1'b1;
    wire  [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    cfg_reg_t              cfg_index = REG_PAT_LOW;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    scan_scoreboard sb;
    bit             calm = 1'b0;     // no idling on either side once set
    bit             tx_live = 1'b0;
    int             stall_pct = 15;
    int             stall_left = 0;
    int             rand_items = 0;
    logic [7:0]     alpha [4];

    wildcard_byte_pattern_scan dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("wildcard_byte_pattern_scan: mismatch");
        $finish;
    end

    // result side: check accepted items, stall in random bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && aresetn && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) < 7) return alpha[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(logic [7:0] b, logic l);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        tx_live = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, l);
    endtask

    task automatic hold_off(int n);
        if (tx_live) begin
            s_tvalid <= 1'b0;
            tx_live = 1'b0;
        end
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        hold_off(1);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic put_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_reg(idx, v);
    endtask

    task automatic write_regs(logic [63:0] lo, logic [63:0] hi,
                              logic [63:0] c, logic [63:0] n);
        put_reg(REG_PAT_LOW, lo);
        put_reg(REG_PAT_HIGH, hi);
        put_reg(REG_CARE, c);
        put_reg(REG_LEN, n);
        cfg_we <= 1'b0;
    endtask

    // one region; optionally plants the pattern (wildcards random), sometimes damaged
    task automatic send_region(int rlen, bit plant, int gap_pct);
        logic [7:0] bytes [$];
        int         n;
        int         pos;
        n = sb.used_len();
        for (int i = 0; i < rlen; i++) bytes = {bytes, pick_byte()};
        if (plant && n > 0 && n <= rlen) begin
            pos = $urandom_range(0, rlen - n);
            for (int j = 0; j < n; j++) begin
                if (sb.care[j]) bytes[pos+j] = sb.pattern[8*j +: 8];
            end
            if ($urandom_range(0, 6) == 0)
                bytes[pos + $urandom_range(0, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
        end
        for (int i = 0; i < rlen; i++) begin
            send_byte(bytes[i], i == rlen - 1);
            rand_items++;
            if (!calm && $urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 8));
        end
    endtask

    initial begin
        logic [127:0] pat;
        logic [15:0]  c;
        logic [4:0]   plen;
        logic [63:0]  c_word;
        logic [63:0]  len_word;
        int           gap_pct;
        int           regions;
        int           n;
        int           p;

        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset pattern is a single 0x00 byte
        send_byte(8'h00, 1'b0);          // match at offset 0
        send_byte(8'h55, 1'b1);          // already reported, no result
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);          // no match
        drain();

        // AA ?? CC
        write_regs(64'h0000_0000_00CC_00AA, 64'h0, 64'h0005, 64'd3);
        send_byte(8'hAA, 1'b1);          // region shorter than pattern
        send_byte(8'h11, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'hCC, 1'b0);          // match at offset 1
        send_byte(8'hCC, 1'b1);          // nothing more in this region
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hCC, 1'b1);          // match on the last byte
        drain();

        // leading wildcard: bad pattern
        write_regs(64'h0000_0000_00CC_00AA, 64'h0, 64'h0004, 64'd3);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hCC, 1'b1);
        drain();

        // zero length: bad pattern
        write_regs(64'h0000_0000_00CC_00AA, 64'h0, 64'h0001, 64'd0);
        send_byte(8'hAA, 1'b1);
        drain();

        p = 0;
        while (rand_items < 900) begin
            for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(0, 255));
            if (p % 3 == 0) alpha[0] = 8'h00;
            else if (p % 3 == 1) alpha[0] = 8'hFF;
            for (int j = 0; j < 16; j++) pat[8*j +: 8] = pick_byte();

            c = 16'($urandom_range(0, 65535));
            c[0] = ($urandom_range(0, 5) != 0);
            if (p == 0 || $urandom_range(0, 7) == 0) c = 16'hFFFF;
            case (p)
                0: plen = 5'd16;
                1: plen = 5'd0;
                2: plen = 5'd31;
                default: begin
                    case ($urandom_range(0, 9))
                        0:       plen = 5'd0;
                        1:       plen = 5'($urandom_range(17, 31));
                        2:       plen = 5'd16;
                        default: plen = 5'($urandom_range(1, 6));
                    endcase
                end
            endcase
            c_word   = {48'd0, c};
            len_word = {59'd0, plen};
            if ($urandom_range(0, 3) == 0) begin
                c_word[63:16]  = {$urandom(), 16'($urandom())};
                len_word[63:5] = {$urandom(), 27'($urandom())};
            end
            write_regs(pat[63:0], pat[127:64], c_word, len_word);

            calm = (rand_items >= 780);
            case (p % 3)
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            stall_pct = 12 * $urandom_range(0, 3);
            n = sb.used_len();
            regions = $urandom_range(3, 10);
            for (int r = 0; r < regions; r++) begin
                send_region($urandom_range(0, 5) == 0 ? 1 : $urandom_range(1, n + 12),
                            $urandom_range(0, 9) < 7, gap_pct);
            end
            // sender waits for every pending result before reconfiguring
            drain();
            p++;
        end

        calm = 1'b1;
        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("wildcard_byte_pattern_scan: match");
        end else begin
            $display("wildcard_byte_pattern_scan: mismatch");
        end
        $finish;
    end

endmodule

// ===== wildcard_byte_pattern_scan.f =====
src/wbps_pkg.sv
src/wbps_cfg.sv
src/wbps_match.sv
src/wbps_track.sv
src/wildcard_byte_pattern_scan.sv
tb/tb_wildcard_byte_pattern_scan.sv
